/* sv/range_set_insert_remove_random_defines.svh */
// ----------------------------------------------------------------------------
// range_set_insert_remove_random_defines
// Assertion macros for the range set block.
// ----------------------------------------------------------------------------
`ifndef RANGE_SET_INSERT_REMOVE_RANDOM_DEFINES_SVH
`define RANGE_SET_INSERT_REMOVE_RANDOM_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define RS_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// Next-cycle implication.
`define RS_ASSERT_NXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

/* sv/rsir_pkg.sv */
// ----------------------------------------------------------------------------
// rsir_pkg
// Shared types and constants of the range set block.
// ----------------------------------------------------------------------------
package rsir_pkg;
  localparam int DEPTH_DEF = 64;
  localparam int BOUND_W = 64;
  localparam int RAND_W = 31;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_FIND   = 2'd2,
    MODE_RANDOM = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_MOD, ST_READ, ST_WRITE, ST_OUT
  } state_t;

  typedef struct packed {
    mode_t              mode;
    logic [BOUND_W-1:0] range_low;
    logic [BOUND_W-1:0] range_high;
    logic [RAND_W-1:0]  random_value;
  } cmd_t;

  typedef struct packed {
    logic               success;
    logic [BOUND_W-1:0] out_low;
    logic [BOUND_W-1:0] out_high;
  } rsp_t;
endpackage

/* sv/rsir_if.sv */
// ----------------------------------------------------------------------------
// rsir_if
// Valid/ready channel carrying one word of payload type.
// ----------------------------------------------------------------------------
interface rsir_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/rsir_cell.sv */
// ----------------------------------------------------------------------------
// rsir_cell
// One table slot: compares its entry against the key and, each cycle that
// shift is high, passes a running equal index and contain flag to the next cell.
// ----------------------------------------------------------------------------
module rsir_cell import rsir_pkg::*; #(
  parameter int IDX_W = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               shift,
  input  logic               active,
  input  logic [BOUND_W-1:0] key_low,
  input  logic [BOUND_W-1:0] key_high,
  input  logic [BOUND_W-1:0] ent_low,
  input  logic [BOUND_W-1:0] ent_high,
  input  logic [IDX_W-1:0]   my_idx,
  input  logic               in_tok,
  input  logic               in_eq,
  input  logic [IDX_W-1:0]   in_pos,
  input  logic               in_con,
  output logic               tok,
  output logic               eq,
  output logic [IDX_W-1:0]   pos,
  output logic               con
);
  logic hit_eq, hit_con;
  assign hit_eq  = active && ent_low == key_low && ent_high == key_high;
  assign hit_con = active && ent_low <= key_low && ent_high >= key_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= 1'b0;
    end else begin
      tok <= shift ? in_tok : 1'b0;
    end
    if (shift) begin
      eq  <= in_eq | hit_eq;
      pos <= in_eq ? in_pos : my_idx;
      con <= in_con | hit_con;
    end
  end
endmodule

/* sv/range_set_insert_remove_random.sv */
// ----------------------------------------------------------------------------
// range_set_insert_remove_random
// Dense range table with add, remove, find containing and get random.
// ----------------------------------------------------------------------------
// channel  dir  payload
// in       in   mode, range_low, range_high, random_value
// out      out  success, out_low, out_high
// Add/remove/find walk the key through the cell chain; get random computes a
//   bit-serial remainder, and on an empty table it skips the read and fails.
// One word in flight; input is taken only in idle, output is registered.
// Reset: synchronous, clears count and control; table needs no clearing.
// Output stall holds the result; the next word waits.
module range_set_insert_remove_random import rsir_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input logic clk,
  input logic rst,
  rsir_if.sink   in,
  rsir_if.source out
);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int STEP_W = $clog2(DEPTH + RAND_W + 2);

  state_t state, state_next;
  logic [BOUND_W-1:0] mem_low [DEPTH];
  logic [BOUND_W-1:0] mem_high [DEPTH];
  logic [CNT_W-1:0] count;
  mode_t mode;
  logic [BOUND_W-1:0] key_low, key_high;
  logic [RAND_W-1:0] rnd;
  logic [CNT_W-1:0] rem;
  logic [STEP_W-1:0] step;
  logic [IDX_W-1:0] rd_addr;
  logic [BOUND_W-1:0] rd_low, rd_high;
  logic found_eq, found_con;
  logic [IDX_W-1:0] found_pos;
  logic res_ok;
  logic [BOUND_W-1:0] res_low, res_high;

  // chain of cells
  logic [DEPTH:0] c_tok, c_eq, c_con;
  logic [IDX_W-1:0] c_pos [DEPTH+1];
  logic [BOUND_W-1:0] c_low [DEPTH];
  logic [BOUND_W-1:0] c_high [DEPTH];
  logic shift;

  assign shift = (state == ST_SCAN);
  assign c_tok[0] = 1'b1;
  assign c_eq[0] = 1'b0;
  assign c_con[0] = 1'b0;
  assign c_pos[0] = '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    assign c_low[g] = mem_low[g];
    assign c_high[g] = mem_high[g];
    rsir_cell #(.IDX_W(IDX_W)) u_cell (
      .clk(clk), .rst(rst), .shift(shift),
      .active(CNT_W'(g) < count),
      .key_low(key_low), .key_high(key_high),
      .ent_low(c_low[g]), .ent_high(c_high[g]),
      .my_idx(IDX_W'(g)),
      .in_tok(c_tok[g]), .in_eq(c_eq[g]), .in_pos(c_pos[g]), .in_con(c_con[g]),
      .tok(c_tok[g+1]), .eq(c_eq[g+1]), .pos(c_pos[g+1]), .con(c_con[g+1])
    );
  end

  assign found_eq = c_eq[DEPTH];
  assign found_pos = c_pos[DEPTH];
  assign found_con = c_con[DEPTH];

  // bit-serial remainder: rem = (rem*2 + bit) mod count
  logic [CNT_W:0] rem2;
  assign rem2 = {rem, rnd[RAND_W-1]};

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in.valid) state_next = (in.data.mode == MODE_RANDOM) ? ST_MOD : ST_SCAN;
      ST_SCAN:  if (c_tok[DEPTH]) state_next = ST_WRITE;
      ST_MOD:   if (count == '0) state_next = ST_OUT;
                else if (step == STEP_W'(RAND_W - 1)) state_next = ST_READ;
      ST_READ:  state_next = ST_OUT;
      ST_WRITE: state_next = ST_OUT;
      ST_OUT:   if (out.ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in.ready = (state == ST_IDLE);
    out.valid = (state == ST_OUT);
    out.data.success = res_ok;
    out.data.out_low = res_low;
    out.data.out_high = res_high;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == ST_WRITE) begin
        if (mode == MODE_ADD && !found_eq && count != CNT_W'(DEPTH)) count <= count + 1'b1;
        if (mode == MODE_REMOVE && found_eq) count <= count - 1'b1;
      end
    end
    if (state == ST_IDLE) begin
      mode <= mode_t'(in.data.mode);
      key_low <= in.data.range_low;
      key_high <= in.data.range_high;
      rnd <= in.data.random_value;
      rem <= '0;
      step <= '0;
      rd_addr <= IDX_W'(count - 1'b1);
      res_ok <= 1'b0;
      res_low <= '0;
      res_high <= '0;
    end
    if (state == ST_MOD) begin
      rem <= (rem2 >= {1'b0, count}) ? CNT_W'(rem2 - {1'b0, count}) : CNT_W'(rem2);
      rnd <= {rnd[RAND_W-2:0], 1'b0};
      step <= step + 1'b1;
    end
    rd_low <= mem_low[rd_addr];
    rd_high <= mem_high[rd_addr];
    if (state == ST_READ) begin
      res_ok <= 1'b1;
      res_low <= mem_low[rem[IDX_W-1:0]];
      res_high <= mem_high[rem[IDX_W-1:0]];
    end
    if (state == ST_WRITE) begin
      case (mode)
        MODE_ADD: if (!found_eq && count != CNT_W'(DEPTH)) begin
          mem_low[count[IDX_W-1:0]] <= key_low;
          mem_high[count[IDX_W-1:0]] <= key_high;
          res_ok <= 1'b1;
        end
        MODE_REMOVE: if (found_eq) begin
          if (found_pos != rd_addr) begin
            mem_low[found_pos] <= rd_low;
            mem_high[found_pos] <= rd_high;
          end
          res_ok <= 1'b1;
        end
        MODE_FIND: res_ok <= found_con;
        default: res_ok <= 1'b0;
      endcase
    end
  end

`include "range_set_insert_remove_random_defines.svh"
  `RS_ASSERT_IMP(a_cnt_max, clk, rst, 1'b1, count <= CNT_W'(DEPTH), "count above depth")
  `RS_ASSERT_IMP(a_busy_noready, clk, rst, state != ST_IDLE, !in.ready, "ready while busy")
  `RS_ASSERT_NXT(a_out_hold, clk, rst, out.valid && !out.ready, out.valid && $stable(res_ok), "result dropped")
endmodule
